FILE: rtl/fqv_pkg.sv
// Shared constants, types and helper functions for the FASTQ record validator.
package fqv_pkg;

   // Line length and counter widths
   localparam int LINE_LENGTH_BITS = 16;
   localparam int COUNT_BITS       = 32;
   localparam int SUM_BITS         = ((COUNT_BITS > LINE_LENGTH_BITS) ?
                                      COUNT_BITS : LINE_LENGTH_BITS) + 1;

   localparam logic [LINE_LENGTH_BITS-1:0] LINE_MAX  = '1;
   localparam logic [COUNT_BITS-1:0]       COUNT_MAX = '1;

   // Result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_LABEL  = 3'd1;
   localparam logic [2:0] ST_BAD_SEQ    = 3'd2;
   localparam logic [2:0] ST_BAD_SEP    = 3'd3;
   localparam logic [2:0] ST_QUAL_LEN   = 3'd4;
   localparam logic [2:0] ST_INCOMPLETE = 3'd5;

   // Record line phases
   localparam logic [1:0] PH_LABEL = 2'd0;
   localparam logic [1:0] PH_SEQ   = 2'd1;
   localparam logic [1:0] PH_SEP   = 2'd2;
   localparam logic [1:0] PH_QUAL  = 2'd3;

   // Characters of interest
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_AT   = 8'h40;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_UA   = 8'h41;
   localparam logic [7:0] CHAR_UC   = 8'h43;
   localparam logic [7:0] CHAR_UG   = 8'h47;
   localparam logic [7:0] CHAR_UT   = 8'h54;
   localparam logic [7:0] CHAR_LA   = 8'h61;
   localparam logic [7:0] CHAR_LC   = 8'h63;
   localparam logic [7:0] CHAR_LG   = 8'h67;
   localparam logic [7:0] CHAR_LT   = 8'h74;

   // Parser and statistics state
   typedef struct packed {
      logic [1:0]                  phase;
      logic [COUNT_BITS-1:0]       lines_done;
      logic [LINE_LENGTH_BITS-1:0] cur_len;
      logic [7:0]                  first_char;
      logic                        nuc_ok;
      logic [LINE_LENGTH_BITS-1:0] last_seq_len;
      logic [2:0]                  status;
      logic                        halted;
      logic [COUNT_BITS-1:0]       reads;
      logic [COUNT_BITS-1:0]       bases;
      logic [LINE_LENGTH_BITS-1:0] min_len;
      logic [LINE_LENGTH_BITS-1:0] max_len;
   } rec_state_type;

   function automatic logic is_base(input logic [7:0] c);
      return (c == CHAR_UA) || (c == CHAR_UC) || (c == CHAR_UG) || (c == CHAR_UT) ||
             (c == CHAR_LA) || (c == CHAR_LC) || (c == CHAR_LG) || (c == CHAR_LT);
   endfunction

   function automatic rec_state_type rec_reset();
      rec_state_type s;
      s              = '0;
      s.phase        = PH_LABEL;
      s.nuc_ok       = 1'b1;
      s.status       = ST_OK;
      s.min_len      = LINE_MAX;
      return s;
   endfunction

endpackage

FILE: rtl/fqv_close_line.sv
// Line-close logic: checks the finished line against its record phase and updates statistics.
module fqv_close_line import fqv_pkg::*; (
   input  rec_state_type st,
   output rec_state_type st_closed
);

   logic [SUM_BITS-1:0] bases_sum;

   assign bases_sum = SUM_BITS'(st.bases) + SUM_BITS'(st.cur_len);

   always_comb begin
      st_closed = st;
      // check the line by its place in the record
      case (st.phase)
         PH_LABEL: begin
            if (st.first_char != CHAR_AT) begin
               st_closed.status = ST_BAD_LABEL;
               st_closed.halted = 1'b1;
            end
         end
         PH_SEQ: begin
            st_closed.last_seq_len = st.cur_len;
            if (st.nuc_ok) begin
               if (st.cur_len < st.min_len) st_closed.min_len = st.cur_len;
               if (st.cur_len > st.max_len) st_closed.max_len = st.cur_len;
               if (bases_sum > SUM_BITS'(COUNT_MAX))
                  st_closed.bases = COUNT_MAX;
               else
                  st_closed.bases = COUNT_BITS'(bases_sum);
            end else begin
               st_closed.status = ST_BAD_SEQ;
            end
         end
         PH_SEP: begin
            if (st.cur_len != LINE_LENGTH_BITS'(1) || st.first_char != CHAR_PLUS) begin
               st_closed.status = ST_BAD_SEP;
               st_closed.halted = 1'b1;
            end
         end
         default: begin
            if (st.cur_len != st.last_seq_len) begin
               st_closed.status = ST_QUAL_LEN;
               st_closed.halted = 1'b1;
            end else begin
               if (st.status == ST_OK && st.reads != COUNT_MAX)
                  st_closed.reads = st.reads + COUNT_BITS'(1);
               if (st.status == ST_BAD_SEQ)
                  st_closed.status = ST_OK;
            end
         end
      endcase
      // advance line count and phase unless halted
      if (!st_closed.halted) begin
         if (st.lines_done != COUNT_MAX)
            st_closed.lines_done = st.lines_done + COUNT_BITS'(1);
         st_closed.phase = st.phase + 2'd1;
      end
      // start a fresh line
      st_closed.cur_len    = '0;
      st_closed.first_char = '0;
      st_closed.nuc_ok     = 1'b1;
   end

endmodule

FILE: rtl/fastq_record_validator.sv
// Top level of the FASTQ record validator: handshake, state and result registers.
//
// Usage: feed a FASTQ file one byte per transaction on the req_ channel
// (req_char_byte, req_end_of_input low). Lines end on newline and are
// checked as four-line records. A transaction with req_end_of_input high
// closes any partial line and produces exactly one result transaction on
// the rsp_ channel with the status, the line index or count, and the read
// statistics; the parser then returns to its reset state for a new file.
// Byte transactions produce no result.
// Throughput: one transaction per cycle, unless an end transaction waits on a
// full, stalled result register; each byte passes an input register, and the
// line and statistics update is a single pass of logic. An accepted end
// transaction passes the input register, then the result register, which drives the result.
// When rsp_stall is high, the result holds in the result register; bytes
// keep flowing, and a later end transaction waits in the input register,
// raising req_stall, until the result register frees up.
// Reset (synchronous, active high) clears the parser state, empties both
// registers and drops rsp_valid.
module fastq_record_validator import fqv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_result_status,
   output logic [31:0] rsp_error_line,
   output logic [31:0] rsp_read_count,
   output logic [31:0] rsp_total_bases,
   output logic [15:0] rsp_shortest_read,
   output logic [15:0] rsp_longest_read
);

   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_eoi_ff;
   rec_state_type st_ff, st_in, st_closed, st_final;
   logic          rsp_valid_ff;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_line_ff, rsp_reads_ff, rsp_bases_ff;
   logic [15:0]   rsp_short_ff, rsp_long_ff;
   logic          in_fire;
   logic          req_accept;

   fqv_close_line u_close (
      .st        (st_ff),
      .st_closed (st_closed)
   );

   // advance the input register unless an end transaction meets a full, stalled result register
   assign in_fire    = in_valid_ff && (!in_eoi_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !in_fire;
   assign req_accept = req_valid && !req_stall;

   // close a partial line at end of input
   assign st_final = (!st_ff.halted && st_ff.cur_len != '0) ? st_closed : st_ff;

   // compute next parser state
   always_comb begin
      st_in = st_ff;
      if (in_fire) begin
         if (in_eoi_ff) begin
            st_in = rec_reset();
         end else if (!st_ff.halted) begin
            if (in_byte_ff == CHAR_LF) begin
               st_in = st_closed;
            end else begin
               if (st_ff.cur_len == '0) st_in.first_char = in_byte_ff;
               if (!is_base(in_byte_ff)) st_in.nuc_ok = 1'b0;
               if (st_ff.cur_len != LINE_MAX)
                  st_in.cur_len = st_ff.cur_len + LINE_LENGTH_BITS'(1);
            end
         end
      end
   end

   // report an unfinished record when nothing failed
   assign rsp_status_in = (st_final.status == ST_OK && st_final.phase != PH_LABEL) ?
                          ST_INCOMPLETE : st_final.status;

   // hold input transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_accept) begin
         in_byte_ff <= req_char_byte;
         in_eoi_ff  <= req_end_of_input;
      end
   end

   // hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= rec_reset();
      end else begin
         st_ff <= st_in;
      end
   end

   // load and drain the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_fire && in_eoi_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (in_fire && in_eoi_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_line_ff   <= 32'(st_final.lines_done);
         rsp_reads_ff  <= 32'(st_final.reads);
         rsp_bases_ff  <= 32'(st_final.bases);
         rsp_short_ff  <= 16'(st_final.min_len);
         rsp_long_ff   <= 16'(st_final.max_len);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_status = rsp_status_ff;
   assign rsp_error_line    = rsp_line_ff;
   assign rsp_read_count    = rsp_reads_ff;
   assign rsp_total_bases   = rsp_bases_ff;
   assign rsp_shortest_read = rsp_short_ff;
   assign rsp_longest_read  = rsp_long_ff;

`ifndef SYNTH
   a_halt_has_code: assert property (@(posedge clock) disable iff (reset)
      st_ff.halted |-> st_ff.status != ST_OK)
      else $error("halted without an error code");

   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("stall raised with an empty input register");

   a_report_resets: assert property (@(posedge clock) disable iff (reset)
      (in_fire && in_eoi_ff) |=> (st_ff.phase == PH_LABEL && st_ff.lines_done == '0 &&
                                  !st_ff.halted && rsp_valid_ff))
      else $error("state not cleared after a report");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_status_ff <= ST_INCOMPLETE)
      else $error("result status out of range");

   a_min_max: assert property (@(posedge clock) disable iff (reset)
      (st_ff.min_len != LINE_MAX) |-> st_ff.min_len <= st_ff.max_len)
      else $error("shortest read exceeds longest read");
`endif

endmodule
